/* rtl/ttps_pkg.sv */
// ----------------------------------------------------------------------------
// ttps_pkg
// Shared types and codes of the transposition table probe and store block.
// ----------------------------------------------------------------------------
`default_nettype none

package ttps_pkg;

  localparam logic [1:0] CMD_PROBE = 2'd0;
  localparam logic [1:0] CMD_STORE = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;

  localparam int KEY_BITS = 64;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [KEY_BITS-1:0] position_key;
    logic [7:0]          search_depth;
    logic signed [15:0]  window_low;
    logic signed [15:0]  window_high;
    logic signed [15:0]  new_score;
    logic [1:0]          bound_kind;
    logic [15:0]         new_move;
  } item_t;

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EVAL  = 3'b100
  } back_state_t;

endpackage

`default_nettype wire

/* rtl/transposition_table_probe_store_core.sv */
// ----------------------------------------------------------------------------
// transposition_table_probe_store_core
// Direct-mapped search-result table with depth-preferred replacement.
//
// Input channel (in_valid/in_ready) carries one command word: probe, store
// or clear; code 3 is taken and ignored. Output channel (out_valid/out_ready)
// carries one result word per probe and nothing for the other commands.
// The slot is the key modulo ENTRIES: its low bits when ENTRIES is a power
// of two, otherwise a reduction in the input stage that folds the key a byte
// at a time and ends with a reciprocal multiply and a single correction.
// The table engine reads an entry and evaluates or writes it in the cycle
// after; a probe waits there while the result register is stalled. The
// engine takes a new word only when it has finished the last one, and the
// input stage only when its word has left. A clear sweeps the valid marks,
// one entry per cycle, through all ENTRIES entries.
// After reset the same sweep runs with in_ready low.
// A stalled receiver holds the result register; a two-word queue and the
// input stage keep taking words until they are full.
// ----------------------------------------------------------------------------
`default_nettype none

module transposition_table_probe_store_core #(
  parameter int ENTRIES   = 4096,
  parameter int MOVE_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         cmd,
  input  wire logic [63:0]        position_key,
  input  wire logic [7:0]         search_depth,
  input  wire logic signed [15:0] window_low,
  input  wire logic signed [15:0] window_high,
  input  wire logic signed [15:0] new_score,
  input  wire logic [1:0]         bound_kind,
  input  wire logic [15:0]        new_move,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    key_hit,
  output logic [15:0]             found_move,
  output logic                    score_usable,
  output logic signed [15:0]      found_score
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QW    = $bits(ttps_pkg::item_t) + IDX_W;

  ttps_pkg::item_t  in_item;
  ttps_pkg::item_t  push_item;
  ttps_pkg::item_t  q_item;
  logic [IDX_W-1:0] push_idx;
  logic [IDX_W-1:0] q_idx;
  logic             push_valid;
  logic             push_ready;
  logic             q_valid;
  logic             q_pop;
  logic [QW-1:0]    q_data;
  logic             init_busy;

  assign in_item.cmd          = cmd;
  assign in_item.position_key = position_key;
  assign in_item.search_depth = search_depth;
  assign in_item.window_low   = window_low;
  assign in_item.window_high  = window_high;
  assign in_item.new_score    = new_score;
  assign in_item.bound_kind   = bound_kind;
  assign in_item.new_move     = new_move;

  ttps_front #(
    .ENTRIES(ENTRIES),
    .IDX_W  (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .init_busy (init_busy),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .push_valid(push_valid),
    .push_ready(push_ready),
    .push_item (push_item),
    .push_idx  (push_idx)
  );

  ttps_queue #(
    .W(QW)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(push_valid),
    .wr_ready(push_ready),
    .wr_data ({push_idx, push_item}),
    .rd_valid(q_valid),
    .rd_pop  (q_pop),
    .rd_data (q_data)
  );

  assign q_item = q_data[$bits(ttps_pkg::item_t)-1:0];
  assign q_idx  = q_data[QW-1:$bits(ttps_pkg::item_t)];

  ttps_back #(
    .ENTRIES  (ENTRIES),
    .MOVE_BITS(MOVE_BITS),
    .IDX_W    (IDX_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .init_busy   (init_busy),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_item      (q_item),
    .q_idx       (q_idx),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .key_hit     (key_hit),
    .found_move  (found_move),
    .score_usable(score_usable),
    .found_score (found_score)
  );

endmodule

`default_nettype wire

/* rtl/ttps_front.sv */
// ----------------------------------------------------------------------------
// ttps_front
// Input stage: takes a word, works out the table slot of its key and hands
// probe, store and clear words to the command queue; unused codes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_front #(
  parameter int ENTRIES = 4096,
  parameter int IDX_W   = 12
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                init_busy,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ttps_pkg::item_t     in_item,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output ttps_pkg::item_t          push_item,
  output logic [IDX_W-1:0]         push_idx
);

  localparam bit POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

  logic            f_valid;
  ttps_pkg::item_t f_item;
  logic            idx_done;
  logic            f_leave;
  logic            accept;

  // 2^(8*pos) modulo the table size
  function automatic longint unsigned byte_weight(input int pos);
    longint unsigned v;
    v = 64'd1 % 64'(ENTRIES);
    for (int i = 0; i < 8 * pos; i++) begin
      v = (v << 1) % 64'(ENTRIES);
    end
    return v;
  endfunction

  assign accept     = in_valid && in_ready;
  assign push_valid = f_valid && idx_done && (f_item.cmd != ttps_pkg::CMD_NOP);
  assign f_leave    = f_valid && idx_done &&
                      ((f_item.cmd == ttps_pkg::CMD_NOP) || push_ready);
  assign in_ready   = !init_busy && (!f_valid || f_leave);
  assign push_item  = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (f_leave) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= in_item;
    end
  end

  generate
    if (POW2) begin : g_mask
      localparam logic [ttps_pkg::KEY_BITS-1:0] IDX_MASK = ttps_pkg::KEY_BITS'(ENTRIES - 1);
      logic [IDX_W-1:0] f_idx;

      always_ff @(posedge clk) begin
        if (accept) begin
          f_idx <= in_item.position_key[IDX_W-1:0] & IDX_MASK[IDX_W-1:0];
        end
      end

      assign idx_done = 1'b1;
      assign push_idx = f_idx;
    end else begin : g_reduce
      // key folded a byte per cycle with constant weights, then one
      // reciprocal multiply and a single correction
      localparam logic [31:0] MOD_C = 32'(ENTRIES);
      localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(ENTRIES));
      logic [3:0]                    steps;
      logic [2:0]                    byte_sel;
      logic [31:0]                   weight [8];
      logic [31:0]                   acc;
      logic [31:0]                   part;
      logic [63:0]                   q_prod;
      logic [31:0]                   q_est;
      logic [31:0]                   qm;
      logic [31:0]                   rem;
      logic [31:0]                   red;
      logic [ttps_pkg::KEY_BITS-1:0] shift;

      for (genvar g = 0; g < 8; g++) begin : g_weight
        localparam logic [31:0] WEIGHT = 32'(byte_weight(g));
        assign weight[g] = WEIGHT;
      end

      assign byte_sel = 3'(4'd10 - steps);
      assign part     = 32'(shift[7:0]) * weight[byte_sel];
      assign q_prod   = 64'(acc) * 64'(RECIP);
      assign qm       = q_est * MOD_C;
      assign red      = (rem >= MOD_C) ? rem - MOD_C : rem;

      always_ff @(posedge clk) begin
        if (rst) begin
          steps <= 4'd0;
        end else if (accept) begin
          steps <= 4'd10;
        end else if (steps != 4'd0) begin
          steps <= steps - 4'd1;
        end
      end

      always_ff @(posedge clk) begin
        if (accept) begin
          acc   <= '0;
          shift <= in_item.position_key;
        end else if (steps >= 4'd3) begin
          acc   <= acc + part;
          shift <= {8'd0, shift[ttps_pkg::KEY_BITS-1:8]};
        end
      end

      always_ff @(posedge clk) begin
        if (steps == 4'd2) begin
          q_est <= q_prod[63:32];
        end
        if (steps == 4'd1) begin
          rem <= acc - qm;
        end
      end

      assign idx_done = steps == 4'd0;
      assign push_idx = red[IDX_W-1:0];
    end
  endgenerate

endmodule

`default_nettype wire

/* rtl/ttps_queue.sv */
// ----------------------------------------------------------------------------
// ttps_queue
// Two-word command queue between the input stage and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_queue #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_valid,
  output logic              wr_ready,
  input  wire logic [W-1:0] wr_data,
  output logic              rd_valid,
  input  wire logic         rd_pop,
  output logic [W-1:0]      rd_data
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_wr;
  logic         do_rd;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/ttps_back.sv */
// ----------------------------------------------------------------------------
// ttps_back
// Table engine: holds the entry memories, runs probes and depth-preferred
// stores as read then evaluate, sweeps the valid marks on clear and reset,
// and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_back #(
  parameter int ENTRIES   = 4096,
  parameter int MOVE_BITS = 16,
  parameter int IDX_W     = 12
) (
  input  wire logic            clk,
  input  wire logic            rst,
  output logic                 init_busy,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire ttps_pkg::item_t q_item,
  input  wire logic [IDX_W-1:0] q_idx,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic                 key_hit,
  output logic [15:0]          found_move,
  output logic                 score_usable,
  output logic signed [15:0]   found_score
);

  localparam int PAY_W = 26 + MOVE_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic                          mem_valid [ENTRIES];
  logic [ttps_pkg::KEY_BITS-1:0] mem_key   [ENTRIES];
  logic [PAY_W-1:0]              mem_pay   [ENTRIES];

  ttps_pkg::back_state_t state;
  ttps_pkg::back_state_t state_next;

  logic [IDX_W-1:0]              sweep_idx;
  logic                          swept_once;
  ttps_pkg::item_t               w_item;
  logic [IDX_W-1:0]              w_idx;
  logic                          rd_valid;
  logic [ttps_pkg::KEY_BITS-1:0] rd_key;
  logic [PAY_W-1:0]              rd_pay;

  logic [7:0]                    s_depth;
  logic signed [15:0]            s_score;
  logic [1:0]                    s_bound;
  logic [MOVE_BITS-1:0]          s_move;
  logic [31:0]                   s_move_ext;
  logic [31:0]                   new_move_ext;
  logic [PAY_W-1:0]              new_pay;
  logic                          hit;
  logic                          bound_ok;
  logic                          usable;
  logic                          take;
  logic                          is_probe;
  logic                          is_store;
  logic                          out_free;
  logic                          probe_done;
  logic                          store_wr;
  logic                          sweep_wr;

  assign s_depth      = rd_pay[7:0];
  assign s_score      = $signed(rd_pay[23:8]);
  assign s_bound      = rd_pay[25:24];
  assign s_move       = rd_pay[PAY_W-1:26];
  assign s_move_ext   = 32'(s_move);
  assign new_move_ext = 32'(w_item.new_move);
  assign new_pay      = {new_move_ext[MOVE_BITS-1:0], w_item.bound_kind,
                         w_item.new_score, w_item.search_depth};

  assign is_probe = w_item.cmd == ttps_pkg::CMD_PROBE;
  assign is_store = w_item.cmd == ttps_pkg::CMD_STORE;
  assign hit      = rd_valid && (rd_key == w_item.position_key);
  assign bound_ok = (s_bound == ttps_pkg::BOUND_EXACT) ||
                    ((s_bound == ttps_pkg::BOUND_LOWER) && (s_score >= w_item.window_high)) ||
                    ((s_bound == ttps_pkg::BOUND_UPPER) && (s_score <= w_item.window_low));
  assign usable   = hit && (s_depth >= w_item.search_depth) && bound_ok;
  assign take     = !rd_valid || (rd_key == w_item.position_key) ||
                    (w_item.search_depth >= s_depth);

  assign out_free   = !out_valid || out_ready;
  assign probe_done = (state == ttps_pkg::ST_EVAL) && is_probe && out_free;
  assign store_wr   = (state == ttps_pkg::ST_EVAL) && is_store && take;
  assign sweep_wr   = state == ttps_pkg::ST_SWEEP;
  assign q_pop      = (state == ttps_pkg::ST_IDLE) && q_valid;
  assign init_busy  = !swept_once;

  always_comb begin
    state_next = state;
    unique case (state)
      ttps_pkg::ST_SWEEP: begin
        if (sweep_idx == LAST_IDX) begin
          state_next = ttps_pkg::ST_IDLE;
        end
      end
      ttps_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = (q_item.cmd == ttps_pkg::CMD_CLEAR) ? ttps_pkg::ST_SWEEP
                                                          : ttps_pkg::ST_EVAL;
        end
      end
      ttps_pkg::ST_EVAL: begin
        if (!is_probe || out_free) begin
          state_next = ttps_pkg::ST_IDLE;
        end
      end
      default: state_next = ttps_pkg::ST_SWEEP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ttps_pkg::ST_SWEEP;
      sweep_idx  <= '0;
      swept_once <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ttps_pkg::ST_SWEEP) begin
        sweep_idx <= (sweep_idx == LAST_IDX) ? '0 : sweep_idx + IDX_W'(1);
        if (sweep_idx == LAST_IDX) begin
          swept_once <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_item <= q_item;
      w_idx  <= q_idx;
    end
  end

  // entry memories
  always_ff @(posedge clk) begin
    if (sweep_wr) begin
      mem_valid[sweep_idx] <= 1'b0;
    end else if (store_wr) begin
      mem_valid[w_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      mem_key[w_idx] <= w_item.position_key;
      mem_pay[w_idx] <= new_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_valid <= mem_valid[q_idx];
      rd_key   <= mem_key[q_idx];
      rd_pay   <= mem_pay[q_idx];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (probe_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (probe_done) begin
      key_hit      <= hit;
      found_move   <= hit ? s_move_ext[15:0] : 16'd0;
      score_usable <= usable;
      found_score  <= usable ? s_score : 16'sd0;
    end
  end

endmodule

`default_nettype wire

/* rtl/ttps_checker.sv */
// ----------------------------------------------------------------------------
// ttps_checker
// Port-level checks of the transposition table probe and store block.
// ----------------------------------------------------------------------------
`default_nettype none

module ttps_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic [1:0]         cmd,
  input wire logic [63:0]        position_key,
  input wire logic [7:0]         search_depth,
  input wire logic signed [15:0] window_low,
  input wire logic signed [15:0] window_high,
  input wire logic signed [15:0] new_score,
  input wire logic [1:0]         bound_kind,
  input wire logic [15:0]        new_move,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               key_hit,
  input wire logic [15:0]        found_move,
  input wire logic               score_usable,
  input wire logic signed [15:0] found_score
);

  // waiting input word stays
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid &&
      $stable({cmd, position_key, search_depth, window_low, window_high,
               new_score, bound_kind, new_move}))
    else $error("input word changed while waiting");

  // stalled result word stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a miss carries no move and no usable score
  a_miss_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_hit |-> (found_move == 16'd0) && !score_usable)
    else $error("miss with move or usable score");

  // unusable score reads as zero
  a_score_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !score_usable |-> found_score == 16'sd0)
    else $error("unusable score not zero");

  // nothing comes out or goes in right after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind transposition_table_probe_store_core ttps_checker u_ttps_checker (.*);

`default_nettype wire
